>>> hw/rtl/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared constants and types for the LRU page frame replacement block.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int MAX_FRAMES_DEFAULT = 16;
  localparam int PAGE_BITS_DEFAULT  = 16;

  // frames_in_use register
  localparam int          CFG_W        = 5;
  localparam logic [4:0]  FRAMES_RESET = 5'd16;

  // result field widths fixed by the interface
  localparam int OUT_IDX_W = 4;
  localparam int TOTAL_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } lpfr_state_t;

endpackage

>>> hw/rtl/lpfr_ram.sv
// ----------------------------------------------------------------------------
// lpfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/lpfr_age.sv
// ----------------------------------------------------------------------------
// lpfr_age
// Frame valid bits and recency ranks. One registered read port for the
// scan, and a single update that ages in parallel every valid frame below the
// limit (every valid frame on a fill) and makes the touched frame the youngest.
// ----------------------------------------------------------------------------
module lpfr_age #(
  parameter int MAX_FRAMES = lpfr_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rd_idx,
  output logic                                                rd_valid,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rd_rank,
  input  logic                                                upd_en,
  input  logic                                                upd_fill,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] upd_frame,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] upd_limit
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(MAX_FRAMES - 1);

  logic             valid [MAX_FRAMES];
  logic [IDX_W-1:0] rank  [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        valid[k] <= 1'b0;
        rank[k]  <= '0;
      end
    end else if (upd_en) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (IDX_W'(k) == upd_frame) begin
          rank[k] <= '0;
          if (upd_fill) begin
            valid[k] <= 1'b1;
          end
        end else if (valid[k] && (upd_fill || rank[k] < upd_limit) &&
                     rank[k] != RANK_MAX) begin
          // age, saturating at the oldest rank
          rank[k] <= rank[k] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_idx];
    rd_rank  <= rank[rd_idx];
  end

endmodule

>>> hw/rtl/lru_page_frame_replacement.sv
// Sequence: an accepted word is scanned against count frames, where count is
//   frames_in_use clamped to 1..MAX_FRAMES; it then passes DRAIN and UPDATE.
// A new word is taken only in IDLE, after the last one has left UPDATE; the
//   pace is set by the frame scan through the single read port of the page memory.
// Reset: valid bits, ranks and totals clear, frames_in_use returns to 16;
//   the page memory is not cleared and the block is ready at once.
// ----------------------------------------------------------------------------
// lru_page_frame_replacement
// LRU page replacement: sequential frame scan over the page memory, a drain
// state, then an update state for ranks, memory write-back and totals.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement #(
  parameter int MAX_FRAMES = lpfr_pkg::MAX_FRAMES_DEFAULT,
  parameter int PAGE_BITS  = lpfr_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpfr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PAGE_BITS-1:0]            page_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [lpfr_pkg::OUT_IDX_W-1:0]  frame_index,
  output logic                            evicted_valid,
  output logic [PAGE_BITS-1:0]            evicted_page,
  output logic [lpfr_pkg::TOTAL_W-1:0]    fault_total,
  output logic [lpfr_pkg::TOTAL_W-1:0]    hit_total
);

  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W     = lpfr_pkg::CFG_W;
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int OUT_IDX_W = lpfr_pkg::OUT_IDX_W;
  localparam int TOTAL_W   = lpfr_pkg::TOTAL_W;

  lpfr_pkg::lpfr_state_t state, state_next;

  logic [CFG_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]     count;
  logic [CMP_W-1:0]     cfg_ext;
  logic [CNT_W-1:0]     iss;
  logic                 last_issue;
  logic                 scan_issue;
  logic                 upd_fire;
  logic                 accept;

  logic [PAGE_BITS-1:0] page;
  logic                 chk_vld;
  logic [IDX_W-1:0]     chk_idx;
  logic [PAGE_BITS-1:0] ram_q;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_rank;

  logic                 found;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     hit_rank;
  logic                 have_empty;
  logic [IDX_W-1:0]     empty_idx;
  logic [IDX_W-1:0]     best_idx;
  logic [IDX_W-1:0]     best_rank;
  logic [PAGE_BITS-1:0] best_page;

  logic [IDX_W-1:0]     upd_frame;
  logic [IDX_W-1:0]     upd_limit;
  logic                 upd_fill;
  logic                 ram_we;

  logic [TOTAL_W-1:0]   hit_cnt;
  logic [TOTAL_W-1:0]   fault_cnt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpfr_pkg::FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  // clamp the frame count into 1..MAX_FRAMES
  assign cfg_ext = CMP_W'(frames_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      count = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
      count = CNT_W'(MAX_FRAMES);
    end else begin
      count = CNT_W'(cfg_ext);
    end
  end

  assign last_issue = (iss == count - CNT_W'(1));

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lpfr_pkg::ST_IDLE:   if (in_valid) state_next = lpfr_pkg::ST_SCAN;
      lpfr_pkg::ST_SCAN:   if (last_issue) state_next = lpfr_pkg::ST_DRAIN;
      lpfr_pkg::ST_DRAIN:  state_next = lpfr_pkg::ST_UPDATE;
      lpfr_pkg::ST_UPDATE: if (!out_valid || out_ready) state_next = lpfr_pkg::ST_IDLE;
      default:             state_next = lpfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    upd_fire   = 1'b0;
    case (state)
      lpfr_pkg::ST_IDLE:   in_ready = 1'b1;
      lpfr_pkg::ST_SCAN:   scan_issue = 1'b1;
      lpfr_pkg::ST_DRAIN:  ;
      lpfr_pkg::ST_UPDATE: upd_fire = !out_valid || out_ready;
      default:             ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // scan issue counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      iss     <= '0;
      chk_vld <= 1'b0;
    end else begin
      if (accept) begin
        iss <= '0;
      end else if (scan_issue) begin
        iss <= iss + CNT_W'(1);
      end
      chk_vld <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= iss[IDX_W-1:0];
    if (accept) begin
      page <= page_number;
    end
  end

  // per-frame check, one frame a cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      found      <= 1'b0;
      have_empty <= 1'b0;
    end else if (chk_vld) begin
      if (!found && rd_valid && ram_q == page) begin
        found    <= 1'b1;
        hit_idx  <= chk_idx;
        hit_rank <= rd_rank;
      end
      if (!have_empty && !rd_valid) begin
        have_empty <= 1'b1;
        empty_idx  <= chk_idx;
      end
      // oldest frame, lowest index wins a tie
      if (chk_idx == '0 || rd_rank > best_rank) begin
        best_idx  <= chk_idx;
        best_rank <= rd_rank;
        best_page <= ram_q;
      end
    end
  end

  // update decision
  always_comb begin
    if (found) begin
      upd_frame = hit_idx;
      upd_limit = hit_rank;
    end else if (have_empty) begin
      upd_frame = empty_idx;
      upd_limit = '0;
    end else begin
      upd_frame = best_idx;
      upd_limit = best_rank;
    end
  end

  assign upd_fill = !found && have_empty;
  assign ram_we   = upd_fire && !found;

  lpfr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_frame),
    .wdata (page),
    .raddr (iss[IDX_W-1:0]),
    .rdata (ram_q)
  );

  lpfr_age #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_age (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (iss[IDX_W-1:0]),
    .rd_valid  (rd_valid),
    .rd_rank   (rd_rank),
    .upd_en    (upd_fire),
    .upd_fill  (upd_fill),
    .upd_frame (upd_frame),
    .upd_limit (upd_limit)
  );

  // running totals, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      fault_cnt <= '0;
    end else if (upd_fire) begin
      if (found) begin
        if (hit_cnt != '1) hit_cnt <= hit_cnt + TOTAL_W'(1);
      end else begin
        if (fault_cnt != '1) fault_cnt <= fault_cnt + TOTAL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      hit           <= found;
      frame_index   <= OUT_IDX_W'(upd_frame);
      evicted_valid <= !found && !have_empty;
      evicted_page  <= (!found && !have_empty) ? best_page : '0;
      fault_total   <= found ? fault_cnt :
                       ((fault_cnt != '1) ? fault_cnt + TOTAL_W'(1) : fault_cnt);
      hit_total     <= !found ? hit_cnt :
                       ((hit_cnt != '1) ? hit_cnt + TOTAL_W'(1) : hit_cnt);
    end
  end

  // checks
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_issue |-> iss < count)
    else $error("scan issued past the frame count");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == lpfr_pkg::ST_SCAN)
    else $error("accepted word did not start a scan");

  a_update_yields_result: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> out_valid)
    else $error("update did not load the result register");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted_valid)
    else $error("hit reported an eviction");

  a_totals_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (hit_cnt >= $past(hit_cnt) && fault_cnt >= $past(fault_cnt)))
    else $error("running total decreased");

endmodule

>>> bench/lru_page_frame_replacement_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_frame_replacement_test
// Drives page references and frame count writes into the LRU page frame
// replacement block, predicts every result with a cycle-free LRU tracker
// and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement_test;

  localparam int NFRAMES     = lpfr_pkg::MAX_FRAMES_DEFAULT;
  localparam int PW          = lpfr_pkg::PAGE_BITS_DEFAULT;
  localparam int CFG_W       = lpfr_pkg::CFG_W;
  localparam int OUT_IDX_W   = lpfr_pkg::OUT_IDX_W;
  localparam int TOTAL_W     = lpfr_pkg::TOTAL_W;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 40;
  localparam int SEG_ITEMS   = 70;

  typedef enum logic [2:0] {
    SEND_PAGE,
    SEND_FRAMES,
    WAIT_EMPTY,
    SET_PHASE,
    HOLD_RESULTS
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [15:0] value;
  } step_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [PW-1:0]        evicted_page;
    logic [TOTAL_W-1:0]   fault_total;
    logic [TOTAL_W-1:0]   hit_total;
  } outcome_t;

  logic clk;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PW-1:0]        page_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 hit;
  logic [OUT_IDX_W-1:0] frame_index;
  logic                 evicted_valid;
  logic [PW-1:0]        evicted_page;
  logic [TOTAL_W-1:0]   fault_total;
  logic [TOTAL_W-1:0]   hit_total;

  lru_page_frame_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total),
    .hit_total     (hit_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // LRU tracker state
  logic [PW-1:0]      frame_pages [NFRAMES];
  logic               frame_used  [NFRAMES];
  logic [3:0]         frame_age   [NFRAMES];
  logic [TOTAL_W-1:0] faults_seen;
  logic [TOTAL_W-1:0] hits_seen;
  logic [CFG_W-1:0]   frames_setting;

  step_t    send_list [$];
  outcome_t outcomes_due [$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_token = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Age every used frame younger than limit, then make frame f the youngest.
  function automatic void age_frames(input int f, input int limit);
    for (int k = 0; k < NFRAMES; k++) begin
      if (k != f && frame_used[k] && int'(frame_age[k]) < limit &&
          int'(frame_age[k]) < NFRAMES - 1)
        frame_age[k] = frame_age[k] + 4'd1;
    end
    frame_age[f] = '0;
  endfunction

  function automatic outcome_t lookup_page(input logic [PW-1:0] pg);
    outcome_t r;
    int       span;
    int       slot;
    int       oldest;
    bit       found;
    bit       have_free;
    r = '0;
    span = (frames_setting == 0) ? 1 :
           (int'(frames_setting) > NFRAMES) ? NFRAMES : int'(frames_setting);
    found = 1'b0;
    slot = 0;
    for (int k = 0; k < span; k++) begin
      if (!found && frame_used[k] && frame_pages[k] == pg) begin
        found = 1'b1;
        slot = k;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (hits_seen != '1) hits_seen = hits_seen + 1;
      age_frames(slot, int'(frame_age[slot]));
    end else begin
      if (faults_seen != '1) faults_seen = faults_seen + 1;
      have_free = 1'b0;
      for (int k = 0; k < span; k++) begin
        if (!have_free && !frame_used[k]) begin
          have_free = 1'b1;
          slot = k;
        end
      end
      if (have_free) begin
        frame_used[slot] = 1'b1;
        frame_pages[slot] = pg;
        age_frames(slot, NFRAMES);
      end else begin
        // lowest index wins a tie on age
        oldest = 0;
        for (int k = 1; k < span; k++)
          if (frame_age[k] > frame_age[oldest]) oldest = k;
        slot = oldest;
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_pages[slot];
        frame_pages[slot] = pg;
        age_frames(slot, int'(frame_age[slot]));
      end
    end
    r.frame_index = slot[OUT_IDX_W-1:0];
    r.fault_total = faults_seen;
    r.hit_total = hits_seen;
    return r;
  endfunction

  task automatic add_step(input step_kind_t kind, input logic [15:0] value);
    step_t s;
    s.kind = kind;
    s.value = value;
    send_list.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Driver: page words and frame count writes, in list order.
  always @(posedge clk) begin : drive
    logic iv;
    logic cv;
    if (rst) begin
      for (int k = 0; k < NFRAMES; k++) begin
        frame_pages[k] = '0;
        frame_used[k] = 1'b0;
        frame_age[k] = '0;
      end
      faults_seen = '0;
      hits_seen = '0;
      frames_setting = lpfr_pkg::FRAMES_RESET;
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      iv = in_valid;
      cv = cfg_valid;
      if (in_valid && in_ready) begin
        outcomes_due.push_back(lookup_page(page_number));
        iv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        frames_setting = cfg_data;
        cv = 1'b0;
      end
      if (!iv && !cv && send_list.size() > 0) begin
        case (send_list[0].kind)
          SEND_PAGE: begin
            if ($urandom_range(99) >= send_idle) begin
              iv = 1'b1;
              page_number <= send_list[0].value;
              void'(send_list.pop_front());
            end
          end
          SEND_FRAMES: begin
            // write only once every result is out
            if (outcomes_due.size() == 0) begin
              cv = 1'b1;
              cfg_data <= send_list[0].value[CFG_W-1:0];
              void'(send_list.pop_front());
            end
          end
          WAIT_EMPTY: begin
            if (outcomes_due.size() == 0) void'(send_list.pop_front());
          end
          SET_PHASE: begin
            case (send_list[0].value)
              16'd0: begin
                send_idle = 38;
                recv_idle = 86;
              end
              16'd1: begin
                send_idle = 86;
                recv_idle = 38;
              end
              default: begin
                send_idle = 0;
                recv_idle = 0;
              end
            endcase
            void'(send_list.pop_front());
          end
          HOLD_RESULTS: begin
            hold_token++;
            void'(send_list.pop_front());
          end
          default: void'(send_list.pop_front());
        endcase
      end
      in_valid <= iv;
      cfg_valid <= cv;
    end
  end

  // Monitor: result words against the oldest prediction; drives out_ready.
  always @(posedge clk) begin : observe
    outcome_t want;
    int       hold_left;
    int       hold_seen;
    if (rst) begin
      hold_left = 0;
      hold_seen = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected", $realtime);
        end else begin
          want = outcomes_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("frame_index", 32'(want.frame_index), 32'(frame_index));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
          check_field("fault_total", want.fault_total, fault_total);
          check_field("hit_total", want.hit_total, hit_total);
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] hot_pages [24];
    int          hot_count;
    int          frames;
    logic [15:0] pg;

    // directed: extremes, hits, fills, evictions, clamped counts, duplicates
    add_step(SET_PHASE, 16'd0);
    add_step(SEND_PAGE, 16'h0000);
    add_step(SEND_PAGE, 16'hFFFF);
    add_step(SEND_PAGE, 16'h0000);
    add_step(SEND_PAGE, 16'hA5A5);
    add_step(SEND_PAGE, 16'h5A5A);
    add_step(SEND_PAGE, 16'hFFFF);
    add_step(SEND_FRAMES, 16'd1);
    add_step(SEND_PAGE, 16'h1234);
    add_step(SEND_PAGE, 16'h1234);
    // resident outside the one frame in use: fault, leaves a duplicate
    add_step(SEND_PAGE, 16'hFFFF);
    add_step(SEND_FRAMES, 16'd16);
    add_step(SEND_PAGE, 16'hFFFF);
    add_step(SEND_PAGE, 16'h0001);
    add_step(SEND_FRAMES, 16'd0);
    add_step(SEND_PAGE, 16'h0002);
    add_step(SEND_PAGE, 16'h0003);
    add_step(SEND_FRAMES, 16'd31);
    add_step(SEND_PAGE, 16'h0002);
    add_step(SEND_PAGE, 16'h8000);
    add_step(SEND_FRAMES, 16'd2);
    add_step(SEND_PAGE, 16'h0010);
    add_step(SEND_PAGE, 16'h0011);
    add_step(SEND_PAGE, 16'h0012);
    add_step(SEND_PAGE, 16'h0010);

    // random: working sets with locality, some stray pages
    for (int phase = 0; phase < 3; phase++) begin
      add_step(WAIT_EMPTY, 16'd0);
      add_step(SET_PHASE, 16'(phase));
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(3))
          0:       frames = $urandom_range(1, 4);
          1:       frames = $urandom_range(0, 31);
          2:       frames = 16;
          default: frames = $urandom_range(5, 15);
        endcase
        add_step(WAIT_EMPTY, 16'd0);
        add_step(SEND_FRAMES, 16'(frames));
        hot_count = $urandom_range(2, 24);
        for (int k = 0; k < hot_count; k++)
          hot_pages[k] = ($urandom_range(3) == 0) ? 16'($urandom_range(31)) :
                                                    16'($urandom_range(65535));
        for (int n = 0; n < SEG_ITEMS; n++) begin
          if (seg == 1 && n == SEG_ITEMS / 2 && phase != 1)
            add_step(HOLD_RESULTS, 16'd0);
          if ($urandom_range(99) < 80)
            pg = hot_pages[$urandom_range(hot_count - 1)];
          else
            pg = 16'($urandom_range(65535));
          add_step(SEND_PAGE, pg);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do
      @(negedge clk);
    while (send_list.size() != 0 || in_valid || cfg_valid || outcomes_due.size() != 0);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
